### rtl/pcwo_pkg.sv
// Shared types and constants of the phase continuous waveform oscillator.
// No dependencies; imported by every module of the block.
package pcwo_pkg;

  // Field widths
  localparam int unsigned FREQ_W     = 23;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned COUNT_W    = 18;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned WAVE_W     = 2;

  // Divider operand widths
  localparam int unsigned DEN_W        = FREQ_W;
  localparam int unsigned PERIOD_NUM_W = RATE_W + 8;
  localparam int unsigned SAW_Q_W      = 15;

  localparam logic [COUNT_W-1:0] PERIOD_MAX  = '1;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;
  localparam logic [SAMPLE_W-1:0] SAW_OFFSET = 16'd16384;

  // Waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 2'd2;

  // Register indexes
  localparam logic REG_WAVEFORM    = 1'b0;
  localparam logic REG_SAMPLE_RATE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/pcwo_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pcwo_pkg (DEN_W, div_status_t).
module pcwo_div #(
  parameter int unsigned NUM_W = 47,
  parameter int unsigned QUO_W = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [NUM_W-1:0]                 num_i,   // left aligned numerator
  input  logic [pcwo_pkg::DEN_W-1:0]       den_i,
  input  logic [pcwo_pkg::DEN_W-1:0]       rem_i,   // partial remainder preload
  input  logic [$clog2(NUM_W+1)-1:0]       steps_i,
  output pcwo_pkg::div_status_t            status_o,
  output logic [QUO_W-1:0]                 quo_o,
  output logic [pcwo_pkg::DEN_W-1:0]       rem_o
);
  import pcwo_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W+1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             take;

  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign take    = ~diff[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= rem_i;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], take};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quo_o         = quo_q;
  assign rem_o         = rem_q;

endmodule

### rtl/pcwo_sine_rom.sv
// Quarter-wave sine ROM with registered read and quadrant unfolding.
// Depends on pcwo_pkg (SAMPLE_W); table built at elaboration.
module pcwo_sine_rom #(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned OUT_BITS        = 16
) (
  input  logic                             clk_i,
  input  logic [TABLE_ADDR_BITS-1:0]       idx_i,
  output logic [pcwo_pkg::SAMPLE_W-1:0]    sample_o
);
  import pcwo_pkg::*;

  localparam int unsigned QSIZE  = 2 ** (TABLE_ADDR_BITS - 2);
  localparam int unsigned ADDR_W = TABLE_ADDR_BITS - 1;
  localparam int unsigned MAG_W  = OUT_BITS - 1;
  localparam int unsigned EXT_W  = OUT_BITS + SAMPLE_W;
  localparam int unsigned SH     = (OUT_BITS >= SAMPLE_W) ? OUT_BITS - SAMPLE_W
                                                          : SAMPLE_W - OUT_BITS;

  typedef logic [MAG_W-1:0] qtab_t [QSIZE+1];

  // sin(pi/2 * k/Q) by a Q30 Horner series, rounded to the output amplitude
  function automatic logic [63:0] qsine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] amp;
    logic [63:0] one;
    one = 64'd1 << 30;
    amp = (64'd1 << (OUT_BITS - 1)) - 64'd1;
    x   = (64'(k) * 64'd1686629713) >> (TABLE_ADDR_BITS - 2);
    x2  = (x * x) >> 30;
    t   = one;
    t   = one - (((x2 * t) >> 30) / 64'd210);
    t   = one - (((x2 * t) >> 30) / 64'd156);
    t   = one - (((x2 * t) >> 30) / 64'd110);
    t   = one - (((x2 * t) >> 30) / 64'd72);
    t   = one - (((x2 * t) >> 30) / 64'd42);
    t   = one - (((x2 * t) >> 30) / 64'd20);
    t   = one - (((x2 * t) >> 30) / 64'd6);
    s   = (x * t) >> 30;
    v   = (s * amp + (64'd1 << 29)) >> 30;
    if (v > amp) v = amp;
    return v;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    int unsigned k;
    for (k = 0; k <= QSIZE; k++) begin
      tab[k] = MAG_W'(qsine(k));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [1:0]             quad;
  logic [ADDR_W-1:0]      r;
  logic [ADDR_W-1:0]      addr;
  logic [MAG_W-1:0]       rom_q;
  logic                   neg_q;
  logic signed [OUT_BITS-1:0] sv;
  logic signed [EXT_W-1:0]    sv_ext;
  logic signed [EXT_W-1:0]    scaled;

  assign quad = idx_i[TABLE_ADDR_BITS-1 -: 2];
  assign r    = {1'b0, idx_i[TABLE_ADDR_BITS-3:0]};
  assign addr = quad[0] ? (ADDR_W'(QSIZE) - r) : r;

  always_ff @(posedge clk_i) begin
    rom_q <= QTAB[addr];
    neg_q <= quad[1];
  end

  always_comb begin
    sv     = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
    sv_ext = {{SAMPLE_W{sv[OUT_BITS-1]}}, sv};
    if (OUT_BITS >= SAMPLE_W) begin
      scaled = sv_ext >>> SH;
    end else begin
      scaled = sv_ext <<< SH;
    end
  end

  assign sample_o = scaled[SAMPLE_W-1:0];

endmodule

### rtl/phase_continuous_waveform_oscillator.sv
// Top level of the phase continuous waveform oscillator.
// Depends on pcwo_pkg, pcwo_div and pcwo_sine_rom.
//
// Usage:
//   s_axis: one transaction per sample tick, tdata carries the wanted frequency
//           (Q8 hertz). m_axis: one transaction per tick, tdata is the Q1.15 sample.
//   cfg:    cfg_we_i writes cfg_wdata_i to register cfg_addr_i (0 waveform,
//           1 sample rate); write only while the block is idle.
// Sequencing:
//   Same frequency as last tick, sine or triangle: IDLE, FORM, FINISH from accept to
//   result, next item accepted the cycle after. Sawtooth: adds ST_DIV_SAW, set
//   by the 15 quotient bits of count*32768/period on the shared divider.
//   A frequency change adds three divider runs on the same unit: phase step
//   (PHASE_BITS+15 quotient bits), period (26 bits), count reduction (18 bits),
//   each launched from the state before it.
//   The sine read on the registered table port is hidden behind the FORM cycle.
// Reset: phase, step and count clear, period is 1, sample rate 48000, sine
//   selected; the first nonzero frequency forces a recompute.
// Stall: the result sits in an output register; a new item may be accepted
//   and worked on meanwhile, and the block then holds until the slot frees.
module phase_continuous_waveform_oscillator #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned OUT_BITS        = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write port
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_addr_i,
  input  logic [pcwo_pkg::RATE_W-1:0]           cfg_wdata_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [pcwo_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [22:0] freq_q8
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [pcwo_pkg::SAMPLE_W-1:0]         m_axis_tdata   // [15:0] sample_out
);
  import pcwo_pkg::*;

  localparam int unsigned NUM_W   = PHASE_BITS + FREQ_W - 8;
  localparam int unsigned QUO_W   = (PHASE_BITS > PERIOD_NUM_W) ? PHASE_BITS : PERIOD_NUM_W;
  localparam int unsigned STEPS_W = $clog2(NUM_W + 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_DIV_STEP   = 3'd1;
  localparam logic [2:0] ST_DIV_PERIOD = 3'd2;
  localparam logic [2:0] ST_DIV_MOD    = 3'd3;
  localparam logic [2:0] ST_FORM       = 3'd4;
  localparam logic [2:0] ST_DIV_SAW    = 3'd5;
  localparam logic [2:0] ST_FINISH     = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [WAVE_W-1:0]     waveform_q;
  logic [RATE_W-1:0]     rate_q;
  logic [PHASE_BITS-1:0] phase_acc_q, phase_acc_d;
  logic [PHASE_BITS-1:0] phase_step_q, phase_step_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [COUNT_W-1:0]    len_q, len_d;
  logic [FREQ_W-1:0]     prev_freq_q, prev_freq_d;
  logic [FREQ_W-1:0]     freq_q, freq_d;
  logic                  out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]   out_data_q, out_data_d;

  // divider request
  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic [DEN_W-1:0]      div_rem_init;
  logic [STEPS_W-1:0]    div_steps;
  div_status_t           div_status;
  logic [QUO_W-1:0]      div_quo;
  logic [DEN_W-1:0]      div_rem;

  logic                  in_xfer;
  logic                  slot_free;
  logic [FREQ_W-1:0]     in_freq;
  logic [COUNT_W-1:0]    len_sat;
  logic [COUNT_W-1:0]    count_inc;
  logic [SAMPLE_W-1:0]   sine_sample;
  logic [SAMPLE_W-1:0]   tri_sample;
  logic [SAMPLE_W-1:0]   saw_sample;
  logic [SAMPLE_W-1:0]   sample;
  logic [PHASE_BITS+16:0] tri_ext;
  logic [16:0]           tri_h;

  pcwo_div #(
    .NUM_W (NUM_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .rem_i    (div_rem_init),
    .steps_i  (div_steps),
    .status_o (div_status),
    .quo_o    (div_quo),
    .rem_o    (div_rem)
  );

  pcwo_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .OUT_BITS        (OUT_BITS)
  ) u_sine (
    .clk_i    (clk_i),
    .idx_i    (phase_acc_q[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
    .sample_o (sine_sample)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign slot_free     = ~out_valid_q | m_axis_tready;
  assign in_freq       = s_axis_tdata[FREQ_W-1:0];

  // period floored at 1, capped at the counter range
  always_comb begin
    if (div_quo[PERIOD_NUM_W-1:COUNT_W] != '0) begin
      len_sat = PERIOD_MAX;
    end else if (div_quo[COUNT_W-1:0] == '0) begin
      len_sat = COUNT_W'(1);
    end else begin
      len_sat = div_quo[COUNT_W-1:0];
    end
  end

  // triangle straight from the top 17 phase bits
  assign tri_ext = {phase_acc_q, 17'd0};
  assign tri_h   = tri_ext[PHASE_BITS+16 -: 17];

  always_comb begin
    case (tri_h[16:15])
      2'd0:    tri_sample = {1'b0, tri_h[14:0]};
      2'd1:    tri_sample = (tri_h[14:0] == '0) ? 16'h7fff
                                                 : 16'(17'h08000 - {2'b00, tri_h[14:0]});
      2'd2:    tri_sample = 16'(17'd0 - {2'b00, tri_h[14:0]});
      default: tri_sample = {1'b1, tri_h[14:0]};
    endcase
  end

  assign saw_sample = SAW_OFFSET - {1'b0, div_quo[SAW_Q_W-1:0]};

  always_comb begin
    case (waveform_q)
      WAVE_SINE:     sample = sine_sample;
      WAVE_TRIANGLE: sample = tri_sample;
      WAVE_SAWTOOTH: sample = saw_sample;
      default:       sample = '0;
    endcase
  end

  assign count_inc = count_q + COUNT_W'(1);

  always_comb begin
    state_d      = state_q;
    phase_acc_d  = phase_acc_q;
    phase_step_d = phase_step_q;
    count_d      = count_q;
    len_d        = len_q;
    prev_freq_d  = prev_freq_q;
    freq_d       = freq_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    div_rem_init = '0;
    div_steps    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          freq_d = in_freq;
          if (in_freq != prev_freq_q) begin
            // step = freq * 2^(PHASE_BITS-8) / rate
            div_start = 1'b1;
            div_num   = {in_freq, {(PHASE_BITS-8){1'b0}}};
            div_den   = DEN_W'(rate_q);
            div_steps = STEPS_W'(NUM_W);
            state_d   = ST_DIV_STEP;
          end else begin
            state_d = ST_FORM;
          end
        end
      end
      ST_DIV_STEP: begin
        if (div_status.done) begin
          phase_step_d = div_quo[PHASE_BITS-1:0];
          // period = rate * 256 / freq
          div_start = 1'b1;
          div_num   = {rate_q, 8'd0, {(NUM_W-PERIOD_NUM_W){1'b0}}};
          div_den   = freq_q;
          div_steps = STEPS_W'(PERIOD_NUM_W);
          state_d   = ST_DIV_PERIOD;
        end
      end
      ST_DIV_PERIOD: begin
        if (div_status.done) begin
          len_d = len_sat;
          // count reduced modulo the new period
          div_start = 1'b1;
          div_num   = {count_q, {(NUM_W-COUNT_W){1'b0}}};
          div_den   = DEN_W'(len_sat);
          div_steps = STEPS_W'(COUNT_W);
          state_d   = ST_DIV_MOD;
        end
      end
      ST_DIV_MOD: begin
        if (div_status.done) begin
          count_d     = div_rem[COUNT_W-1:0];
          prev_freq_d = freq_q;
          state_d     = ST_FORM;
        end
      end
      ST_FORM: begin
        if (waveform_q == WAVE_SAWTOOTH) begin
          // count < period, so the remainder preload is already reduced
          div_start    = 1'b1;
          div_rem_init = DEN_W'(count_q);
          div_den      = DEN_W'(len_q);
          div_steps    = STEPS_W'(SAW_Q_W);
          state_d      = ST_DIV_SAW;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV_SAW: begin
        if (div_status.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_data_d  = sample;
          out_valid_d = 1'b1;
          phase_acc_d = phase_acc_q + phase_step_q;
          count_d     = (count_inc == len_q) ? '0 : count_inc;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      waveform_q   <= WAVE_SINE;
      rate_q       <= RATE_RESET;
      phase_acc_q  <= '0;
      phase_step_q <= '0;
      count_q      <= '0;
      len_q        <= COUNT_W'(1);
      prev_freq_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_acc_q  <= phase_acc_d;
      phase_step_q <= phase_step_d;
      count_q      <= count_d;
      len_q        <= len_d;
      prev_freq_q  <= prev_freq_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_WAVEFORM:    waveform_q <= cfg_wdata_i[WAVE_W-1:0];
          REG_SAMPLE_RATE: rate_q     <= cfg_wdata_i;
          default:         rate_q     <= rate_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q     <= freq_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/pcwo_checker.sv
// Port-level checker for the oscillator, attached by the bind below.
// Depends on pcwo_pkg and phase_continuous_waveform_oscillator.
module pcwo_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic [pcwo_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [pcwo_pkg::SAMPLE_W-1:0]         m_axis_tdata
);
  import pcwo_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_q;
  logic [1:0] pend_d;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // transactions accepted but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) pend_d = pend_q + 2'd1;
    if (!in_xfer && out_xfer) pend_d = pend_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without a pending input");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two inputs outstanding");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input accepted while previous item in work");

endmodule

bind phase_continuous_waveform_oscillator pcwo_checker u_pcwo_checker (.*);
